@@ src/dttf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dttf_pkg;

  // default number format: Q15.16
  localparam int FRAC_BITS_DEF = 16;
  localparam int INT_BITS_DEF  = 15;
  localparam int VALUE_W       = 32;
  localparam int CHAR_W        = 8;
  localparam int DIGIT_W       = 4;
  localparam int RADIX         = 10;

  // fraction weights: slot k holds floor(2^frac_bits / 10^(k+1)), last slot is zero
  localparam int WEIGHT_SLOTS = 11;
  localparam int WIDX_W       = $clog2(WEIGHT_SLOTS);
  localparam logic [WIDX_W-1:0] WIDX_LAST = WIDX_W'(WEIGHT_SLOTS - 1);

  // character codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_INT,
    PH_FRAC,
    PH_TRAIL
  } phase_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              is_last;
  } text_beat_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      bad_syntax;
  } num_beat_t;

  typedef logic [63:0] weight_arr_t [WEIGHT_SLOTS];

  // elaboration-time weight table
  function automatic weight_arr_t make_weights(input int frac_bits);
    weight_arr_t w;
    logic [63:0] acc;
    acc = 64'd1 << frac_bits;
    for (int k = 0; k < WEIGHT_SLOTS; k++) begin
      acc  = acc / RADIX;
      w[k] = acc;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

@@ src/dttf_parse.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dttf_parse #(
  parameter int FRAC_BITS = dttf_pkg::FRAC_BITS_DEF,
  parameter int INT_BITS  = dttf_pkg::INT_BITS_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   step,
  input  dttf_pkg::text_beat_t  item,
  output dttf_pkg::num_beat_t   result
);

  localparam dttf_pkg::weight_arr_t WEIGHTS = dttf_pkg::make_weights(FRAC_BITS);
  localparam int ACC_W  = INT_BITS + dttf_pkg::DIGIT_W;
  localparam int PROD_W = FRAC_BITS + dttf_pkg::DIGIT_W;
  localparam int MAG_W  = INT_BITS + FRAC_BITS;
  localparam logic [INT_BITS-1:0] INT_MAX = '1;

  dttf_pkg::phase_t              phase, phase_next;
  logic                          negative, negative_next;
  logic [INT_BITS-1:0]           int_acc, int_acc_next;
  logic [FRAC_BITS-1:0]          frac_acc, frac_acc_next;
  logic [dttf_pkg::WIDX_W-1:0]   widx, widx_next;
  logic                          error_seen, error_next;

  logic [dttf_pkg::CHAR_W-1:0]   c;
  logic                          is_digit, is_space, is_sign, is_dot;
  logic                          in_lead, in_int;
  logic [dttf_pkg::DIGIT_W-1:0]  d;
  logic [ACC_W-1:0]              int_prod;
  logic [FRAC_BITS-1:0]          weight;
  logic [PROD_W-1:0]             frac_prod;
  logic [PROD_W-1:0]             frac_sum;
  logic [MAG_W-1:0]              mag_wide;
  logic [dttf_pkg::VALUE_W-1:0]  mag;

  // character classes
  always_comb begin
    c        = item.char_code;
    is_digit = (c >= dttf_pkg::CH_ZERO) && (c <= dttf_pkg::CH_NINE);
    is_space = (c == dttf_pkg::CH_SPACE) ||
               ((c >= dttf_pkg::CH_TAB) && (c <= dttf_pkg::CH_CR));
    is_sign  = (c == dttf_pkg::CH_PLUS) || (c == dttf_pkg::CH_MINUS);
    is_dot   = (c == dttf_pkg::CH_DOT);
    d        = is_digit ? dttf_pkg::DIGIT_W'(c - dttf_pkg::CH_ZERO) : '0;
    in_lead  = (phase == dttf_pkg::PH_LEAD);
    in_int   = (phase == dttf_pkg::PH_INT);
  end

  // digit arithmetic: integer times ten plus digit, fraction plus digit times weight
  always_comb begin
    int_prod  = ACC_W'(int_acc) * ACC_W'(dttf_pkg::RADIX) + ACC_W'(d);
    weight    = FRAC_BITS'(WEIGHTS[widx]);
    frac_prod = PROD_W'(d) * PROD_W'(weight);
    frac_sum  = PROD_W'(frac_acc) + frac_prod;
  end

  // next state for one character
  always_comb begin
    phase_next    = phase;
    negative_next = negative;
    int_acc_next  = int_acc;
    frac_acc_next = frac_acc;
    widx_next     = widx;
    error_next    = error_seen;
    if (!error_seen) begin
      priority if (is_space) begin
        if (in_int || phase == dttf_pkg::PH_FRAC) begin
          phase_next = dttf_pkg::PH_TRAIL;
        end
      end else if (in_lead && is_sign) begin
        negative_next = (c == dttf_pkg::CH_MINUS);
        phase_next    = dttf_pkg::PH_INT;
      end else if ((in_lead || in_int) && is_dot) begin
        phase_next = dttf_pkg::PH_FRAC;
      end else if (is_digit && (in_lead || in_int)) begin
        phase_next   = dttf_pkg::PH_INT;
        int_acc_next = (int_prod > ACC_W'(INT_MAX)) ? INT_MAX : INT_BITS'(int_prod);
      end else if (is_digit && phase == dttf_pkg::PH_FRAC) begin
        frac_acc_next = FRAC_BITS'(frac_sum);
        if (widx != dttf_pkg::WIDX_LAST) begin
          widx_next = widx + 1'b1;
        end
      end else begin
        error_next = 1'b1;
      end
    end
  end

  // result from the updated state; the fraction never reaches one, so it packs below the integer
  always_comb begin
    mag_wide          = {int_acc_next, frac_acc_next};
    mag               = dttf_pkg::VALUE_W'(mag_wide);
    result.value      = negative_next ? -mag : mag;
    result.bad_syntax = error_next;
  end

  // state registers, cleared by reset and after the last character of a string
  always_ff @(posedge clk) begin
    if (rst || (step && item.is_last)) begin
      phase      <= dttf_pkg::PH_LEAD;
      negative   <= 1'b0;
      int_acc    <= '0;
      frac_acc   <= '0;
      widx       <= '0;
      error_seen <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      negative   <= negative_next;
      int_acc    <= int_acc_next;
      frac_acc   <= frac_acc_next;
      widx       <= widx_next;
      error_seen <= error_next;
    end
  end

  // string end returns the parser to its start
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    step && item.is_last |=> phase == dttf_pkg::PH_LEAD && !error_seen && !negative &&
                             int_acc == '0 && frac_acc == '0 && widx == '0)
    else $error("parser not cleared after last character");

  // an error holds until the string ends
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    error_seen && !(step && item.is_last) |=> error_seen)
    else $error("error flag dropped inside a string");

  // weight index stays within the table
  a_widx_range: assert property (@(posedge clk) disable iff (rst)
    widx <= dttf_pkg::WIDX_LAST)
    else $error("weight index out of range");

endmodule

`default_nettype wire

@@ src/dttf_out_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dttf_out_reg (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  load,
  input  dttf_pkg::num_beat_t  din,
  output logic                 ready,
  output logic                 valid,
  input  wire                  stall,
  output dttf_pkg::num_beat_t  dout
);

  // free when empty or when the held beat leaves this cycle
  assign ready = !valid || !stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ready && load) begin
      dout <= din;
    end
  end

  // a result is never loaded over a held beat
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    valid && stall |=> valid && $stable(dout))
    else $error("held result lost or changed");

endmodule

`default_nettype wire

@@ src/decimal_text_to_fixed.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel | beat type              | handshake                  | content
// text    | dttf_pkg::text_beat_t  | text_valid / text_stall    | one character, last flag
// num     | dttf_pkg::num_beat_t   | num_valid / num_stall      | fixed point value, error flag
//
// one character a cycle sustained while text_stall is low; a character is held in the input register,
// and the result of a string's last character is loaded from there into the output register.
// rst (synchronous) clears the parser to the leading whitespace phase and empties both registers.
// text_stall rises only when the last character of a string waits behind a stalled result beat.

module decimal_text_to_fixed #(
  parameter int FRAC_BITS = dttf_pkg::FRAC_BITS_DEF,
  parameter int INT_BITS  = dttf_pkg::INT_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  text_valid,
  output logic                 text_stall,
  input  dttf_pkg::text_beat_t text,
  output logic                 num_valid,
  input  wire                  num_stall,
  output dttf_pkg::num_beat_t  num
);

  logic                 s1_valid;
  dttf_pkg::text_beat_t s1_item;
  logic                 s1_go;
  logic                 step;
  logic                 out_ready;
  dttf_pkg::num_beat_t  result;

  // input register moves on unless its last character needs a free result slot
  assign s1_go      = !s1_item.is_last || out_ready;
  assign step       = s1_valid && s1_go;
  assign text_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!text_stall) begin
      s1_valid <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && !text_stall) begin
      s1_item <= text;
    end
  end

  // parser state and per-character logic
  dttf_parse #(
    .FRAC_BITS (FRAC_BITS),
    .INT_BITS  (INT_BITS)
  ) u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (s1_item),
    .result (result)
  );

  // result register
  dttf_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (step && s1_item.is_last),
    .din   (result),
    .ready (out_ready),
    .valid (num_valid),
    .stall (num_stall),
    .dout  (num)
  );

  // a stall on the input side is always caused by a waiting last character
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    text_stall |-> s1_valid && s1_item.is_last && num_valid && num_stall)
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  typedef logic [dttf_pkg::CHAR_W-1:0] char_list_t[$];

  localparam int          IDLE_LIMIT = 2000;
  localparam int          HOLD_START = 400;
  localparam int          HOLD_LEN   = 200;
  localparam logic [31:0] INT_CAP    = (32'd1 << dttf_pkg::INT_BITS_DEF) - 1;
  localparam logic [31:0] TENTH      = (32'd1 << dttf_pkg::FRAC_BITS_DEF) / dttf_pkg::RADIX;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 text_valid = 1'b0;
  logic                 text_stall;
  dttf_pkg::text_beat_t text = '0;
  logic                 num_valid;
  logic                 num_stall = 1'b0;
  dttf_pkg::num_beat_t  num;

  decimal_text_to_fixed dut (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text       (text),
    .num_valid  (num_valid),
    .num_stall  (num_stall),
    .num        (num)
  );

  always #6 clk = ~clk;

  // characters waiting to be sent, numbers waiting to come back
  dttf_pkg::text_beat_t char_queue[$];
  dttf_pkg::num_beat_t  due_numbers[$];

  bit calm = 1'b0;
  int n_strings = 0;
  int n_chars = 0;
  int n_numbers = 0;
  int n_flagged = 0;
  int errs = 0;

  // parser state mirrored on the testbench side
  dttf_pkg::phase_t ps_phase = dttf_pkg::PH_LEAD;
  logic             ps_neg = 1'b0;
  logic [31:0]      ps_int = '0;
  logic [31:0]      ps_frac = '0;
  logic [31:0]      ps_weight = TENTH;
  logic             ps_err = 1'b0;

  function automatic void clear_parser();
    ps_phase  = dttf_pkg::PH_LEAD;
    ps_neg    = 1'b0;
    ps_int    = '0;
    ps_frac   = '0;
    ps_weight = TENTH;
    ps_err    = 1'b0;
  endfunction

  function automatic void parse_char(input logic [dttf_pkg::CHAR_W-1:0] c);
    logic        is_digit;
    logic        is_ws;
    logic        in_lead;
    logic        in_int;
    logic [31:0] d;
    is_digit = (c >= dttf_pkg::CH_ZERO) && (c <= dttf_pkg::CH_NINE);
    d        = is_digit ? 32'(c - dttf_pkg::CH_ZERO) : 32'd0;
    is_ws    = (c == dttf_pkg::CH_SPACE) ||
               ((c >= dttf_pkg::CH_TAB) && (c <= dttf_pkg::CH_CR));
    in_lead  = (ps_phase == dttf_pkg::PH_LEAD);
    in_int   = (ps_phase == dttf_pkg::PH_INT);
    // once in error, the rest of the string is ignored
    if (ps_err) return;
    if (is_ws) begin
      if (in_int || ps_phase == dttf_pkg::PH_FRAC) begin
        ps_phase = dttf_pkg::PH_TRAIL;
      end
    end else if (in_lead && (c == dttf_pkg::CH_PLUS || c == dttf_pkg::CH_MINUS)) begin
      ps_neg   = (c == dttf_pkg::CH_MINUS);
      ps_phase = dttf_pkg::PH_INT;
    end else if ((in_lead || in_int) && c == dttf_pkg::CH_DOT) begin
      ps_phase = dttf_pkg::PH_FRAC;
    end else if (is_digit && (in_lead || in_int)) begin
      ps_phase = dttf_pkg::PH_INT;
      // saturate the integer part
      if (ps_int > (INT_CAP - d) / dttf_pkg::RADIX) ps_int = INT_CAP;
      else ps_int = ps_int * dttf_pkg::RADIX + d;
    end else if (is_digit && ps_phase == dttf_pkg::PH_FRAC) begin
      ps_frac   = ps_frac + d * ps_weight;
      ps_weight = ps_weight / dttf_pkg::RADIX;
    end else begin
      ps_err = 1'b1;
    end
  endfunction

  function automatic dttf_pkg::num_beat_t finish_number();
    dttf_pkg::num_beat_t r;
    logic [63:0]         mag;
    mag = (64'(ps_int) << dttf_pkg::FRAC_BITS_DEF) + 64'(ps_frac);
    if (ps_neg) mag = -mag;
    r.value      = mag[dttf_pkg::VALUE_W-1:0];
    r.bad_syntax = ps_err;
    return r;
  endfunction

  function automatic logic [dttf_pkg::CHAR_W-1:0] pick_space();
    if ($urandom_range(0, 5) == 5) return dttf_pkg::CH_SPACE;
    return dttf_pkg::CHAR_W'(dttf_pkg::CH_TAB + $urandom_range(0, 4));
  endfunction

  function automatic logic [dttf_pkg::CHAR_W-1:0] pick_digit();
    return dttf_pkg::CHAR_W'(dttf_pkg::CH_ZERO + $urandom_range(0, 9));
  endfunction

  task automatic push_chars(input char_list_t cs);
    foreach (cs[i]) char_queue.push_back('{char_code: cs[i], is_last: (i == cs.size() - 1)});
    n_chars += cs.size();
    n_strings++;
  endtask

  task automatic push_str(input string s);
    char_list_t cs;
    for (int i = 0; i < s.len(); i++) cs.push_back(s[i]);
    push_chars(cs);
  endtask

  // sender: one beat offered at a time, held while stalled
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
      gap_left   <= 0;
    end else if (!text_valid || !text_stall) begin
      if (gap_left != 0) begin
        text_valid <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (char_queue.size() != 0 && !calm && $urandom_range(0, 7) == 0) begin
        text_valid <= 1'b0;
        gap_left   <= $urandom_range(0, 3);
      end else if (char_queue.size() != 0) begin
        text_valid <= 1'b1;
        text       <= char_queue.pop_front();
      end else begin
        text_valid <= 1'b0;
      end
    end
  end

  // receiver stall: short random bursts plus one long hold-off
  int stall_left = 0;
  int hold_left = 0;
  int cyc = 0;
  always @(posedge clk) begin
    if (rst) begin
      num_stall  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
      cyc        <= 0;
    end else begin
      cyc <= cyc + 1;
      if (cyc == HOLD_START) begin
        num_stall <= 1'b1;
        hold_left <= HOLD_LEN;
      end else if (hold_left != 0) begin
        num_stall <= (hold_left > 1);
        hold_left <= hold_left - 1;
      end else if (stall_left != 0) begin
        num_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        num_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 3);
      end else begin
        num_stall <= 1'b0;
      end
    end
  end

  // monitor: check result beats first, then predict from the text beat
  always @(posedge clk) begin
    dttf_pkg::num_beat_t want;
    if (!rst) begin
      if (num_valid && !num_stall) begin
        n_numbers++;
        if (num.bad_syntax) n_flagged++;
        if (due_numbers.size() == 0) begin
          $error("result beat with none due: value %0d bad_syntax %0b",
                 num.value, num.bad_syntax);
          errs++;
        end else begin
          want = due_numbers.pop_front();
          if (num.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, num.value);
            errs++;
          end
          if (num.bad_syntax !== want.bad_syntax) begin
            $error("bad_syntax: expected %0b, got %0b", want.bad_syntax, num.bad_syntax);
            errs++;
          end
        end
      end
      if (text_valid && !text_stall) begin
        parse_char(text.char_code);
        if (text.is_last) begin
          due_numbers.push_back(finish_number());
          clear_parser();
        end
      end
    end
  end

  // watchdog on cycles with no beat moving
  int idle_cyc = 0;
  always @(posedge clk) begin
    if (rst || (text_valid && !text_stall) || (num_valid && !num_stall)) begin
      idle_cyc <= 0;
    end else if (idle_cyc == IDLE_LIMIT) begin
      $display("timeout: %0d results still due", due_numbers.size());
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  initial begin
    char_list_t cs;
    int         sel;
    // directed: blank, sign and dot only, saturation, signed fraction with
    // trailing space, space inside the number, second sign, second dot,
    // fraction past the point where the weight runs out, code 0 and code 255
    push_str(" ");
    push_str("-.");
    push_str("99999");
    push_str("-1.5\t");
    push_str("1 2");
    push_str("--");
    push_str("..");
    push_str(".999999");
    cs = {8'h00};
    push_chars(cs);
    cs = {8'hFF};
    push_chars(cs);

    // random: mostly well-formed numbers, some corrupted, some pure noise
    while (n_chars < 1500) begin
      cs = {};
      if ($urandom_range(0, 4) != 0) begin
        repeat ($urandom_range(0, 2)) cs.push_back(pick_space());
        sel = $urandom_range(0, 2);
        if (sel == 1) cs.push_back(dttf_pkg::CH_PLUS);
        if (sel == 2) cs.push_back(dttf_pkg::CH_MINUS);
        sel = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
        repeat (sel) cs.push_back(pick_digit());
        if ($urandom_range(0, 1) == 1) begin
          cs.push_back(dttf_pkg::CH_DOT);
          repeat ($urandom_range(0, 8)) cs.push_back(pick_digit());
        end
        repeat ($urandom_range(0, 2)) cs.push_back(pick_space());
        if ($urandom_range(0, 4) == 0) begin
          case ($urandom_range(0, 5))
            0: cs.insert($urandom_range(0, cs.size()), dttf_pkg::CH_DOT);
            1: cs.insert($urandom_range(0, cs.size()), dttf_pkg::CH_PLUS);
            2: cs.insert($urandom_range(0, cs.size()), dttf_pkg::CH_MINUS);
            3: cs.insert($urandom_range(0, cs.size()), pick_digit());
            4: cs.insert($urandom_range(0, cs.size()), pick_space());
            default: cs.insert($urandom_range(0, cs.size()),
                               dttf_pkg::CHAR_W'($urandom_range(0, 255)));
          endcase
        end
        if (cs.size() == 0) cs.push_back(dttf_pkg::CH_SPACE);
      end else begin
        repeat ($urandom_range(1, 6)) cs.push_back(dttf_pkg::CHAR_W'($urandom_range(0, 255)));
      end
      push_chars(cs);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // last stretch runs with no idling on either side
    while (char_queue.size() >= 150) @(negedge clk);
    calm = 1'b1;

    while (char_queue.size() != 0 || text_valid) @(negedge clk);
    while (due_numbers.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("sent %0d strings in %0d characters; checked %0d numbers, %0d with bad syntax",
             n_strings, n_chars, n_numbers, n_flagged);
    if (errs == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
